// File: rtl/cbfl_pkg.sv
// ----------------------------------------------------------------------------
// cbfl_pkg
// Shared codes for the child box flow layout: layout modes and register map.
// ----------------------------------------------------------------------------
package cbfl_pkg;

  // layout mode register codes; the spare code falls back to block flow
  typedef enum logic [1:0] {
    MODE_BLOCKS  = 2'd0,
    MODE_ROWS    = 2'd1,
    MODE_COLUMNS = 2'd2
  } cbfl_mode_t;

  localparam int unsigned CFG_IDX_BITS = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LAYOUT_MODE = 4'd0,
    REG_INNER_WIDTH = 4'd1
  } cbfl_reg_t;

endpackage

// File: rtl/child_box_flow_layout.sv
// ----------------------------------------------------------------------------
// child_box_flow_layout
// Flow layout of child boxes with line wrap, rows and columns modes.
// ----------------------------------------------------------------------------
// One child per cycle unless stalled: each transfer is placed in the cycle
// it is accepted, against the running cursor and extent registers. A
// two-entry output buffer (result register plus skid register) registers the
// result and keeps the input open while one result waits; in_stall rises
// only when both entries are full. Configuration writes are always taken
// (cfg_ready is tied high) and must be made while no child is in flight.
// The running state clears after each child marked last_child.
module child_box_flow_layout
  import cbfl_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [COORD_BITS-1:0]   in_child_width,
  input  logic [COORD_BITS-1:0]   in_child_height,
  input  logic                    in_is_absolute,
  input  logic                    in_last_child,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [COORD_BITS-1:0]   out_offset_x,
  output logic [COORD_BITS-1:0]   out_offset_y,
  output logic [COORD_BITS-1:0]   out_total_width,
  output logic [COORD_BITS-1:0]   out_total_height,
  output logic                    out_last,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]   cfg_data
);

  localparam int unsigned RES_BITS = 4 * COORD_BITS + 1;

  logic [1:0]            mode_r;
  logic [COORD_BITS-1:0] inner_w_r;

  logic                  in_xfer;
  logic                  out_free;
  logic [COORD_BITS-1:0] p_ox, p_oy, p_cw, p_ch;
  logic [RES_BITS-1:0]   res_new;
  logic [RES_BITS-1:0]   out_data_r;
  logic [RES_BITS-1:0]   skid_data_r;
  logic                  out_valid_r;
  logic                  skid_valid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_BLOCKS;
      inner_w_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LAYOUT_MODE: mode_r    <= cfg_data[1:0];
        REG_INNER_WIDTH: inner_w_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid_r;
  assign in_xfer  = in_valid && !skid_valid_r;

  cbfl_place #(
    .COORD_BITS (COORD_BITS)
  ) u_place (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_xfer),
    .layout_mode  (mode_r),
    .inner_width  (inner_w_r),
    .child_width  (in_child_width),
    .child_height (in_child_height),
    .is_absolute  (in_is_absolute),
    .last_child   (in_last_child),
    .offset_x     (p_ox),
    .offset_y     (p_oy),
    .total_width  (p_cw),
    .total_height (p_ch)
  );

  assign res_new  = {p_ox, p_oy, p_cw, p_ch, in_last_child};
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_xfer) begin
        out_data_r <= res_new;
      end
    end else if (in_xfer) begin
      skid_data_r <= res_new;
    end
  end

  assign out_valid = out_valid_r;
  assign {out_offset_x, out_offset_y, out_total_width, out_total_height, out_last} =
    out_data_r;

endmodule

// File: rtl/cbfl_place.sv
// ----------------------------------------------------------------------------
// cbfl_place
// Running layout state and the combinational placement of one child box.
// ----------------------------------------------------------------------------
module cbfl_place
  import cbfl_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [1:0]            layout_mode,
  input  logic [COORD_BITS-1:0] inner_width,
  input  logic [COORD_BITS-1:0] child_width,
  input  logic [COORD_BITS-1:0] child_height,
  input  logic                  is_absolute,
  input  logic                  last_child,
  output logic [COORD_BITS-1:0] offset_x,
  output logic [COORD_BITS-1:0] offset_y,
  output logic [COORD_BITS-1:0] total_width,
  output logic [COORD_BITS-1:0] total_height
);

  function automatic logic [COORD_BITS-1:0] sat_add(input logic [COORD_BITS-1:0] a,
                                                    input logic [COORD_BITS-1:0] b);
    logic [COORD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COORD_BITS] ? {COORD_BITS{1'b1}} : s[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] umax(input logic [COORD_BITS-1:0] a,
                                                 input logic [COORD_BITS-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic [COORD_BITS-1:0] cursor_x_r, cursor_x_nxt;
  logic [COORD_BITS-1:0] cursor_y_r, cursor_y_nxt;
  logic [COORD_BITS-1:0] line_h_r, line_h_nxt;
  logic [COORD_BITS-1:0] ext_w_r, ext_w_nxt;
  logic [COORD_BITS-1:0] ext_h_r, ext_h_nxt;

  logic                  blocks;
  logic [COORD_BITS:0]   reach;
  logic                  wrap;
  logic [COORD_BITS-1:0] bx, by, bline;
  logic [COORD_BITS-1:0] fx, fy, fline, few, feh;

  assign blocks = !((layout_mode == MODE_ROWS) || (layout_mode == MODE_COLUMNS));

  // block flow: wrap test uses the exact sum, not the saturated one
  assign reach = {1'b0, cursor_x_r} + {1'b0, child_width};
  assign wrap  = reach > {1'b0, inner_width};
  assign bx    = wrap ? '0 : cursor_x_r;
  assign by    = (wrap && (cursor_x_r != '0)) ? sat_add(cursor_y_r, line_h_r) : cursor_y_r;
  assign bline = wrap ? '0 : line_h_r;

  always_comb begin
    fx    = cursor_x_r;
    fy    = cursor_y_r;
    fline = line_h_r;
    few   = ext_w_r;
    feh   = ext_h_r;
    offset_x = '0;
    offset_y = '0;
    if (!is_absolute) begin
      case (layout_mode)
        MODE_ROWS: begin
          offset_x = cursor_x_r;
          offset_y = cursor_y_r;
          fy  = sat_add(cursor_y_r, child_height);
          feh = sat_add(ext_h_r, child_height);
          few = umax(ext_w_r, child_width);
        end
        MODE_COLUMNS: begin
          offset_x = cursor_x_r;
          offset_y = cursor_y_r;
          fx  = sat_add(cursor_x_r, child_width);
          few = sat_add(ext_w_r, child_width);
          feh = umax(ext_h_r, child_height);
        end
        default: begin
          offset_x = bx;
          offset_y = by;
          fy    = by;
          fline = umax(bline, child_height);
          fx    = sat_add(bx, child_width);
          few   = umax(ext_w_r, fx);
          feh   = umax(ext_h_r, by);
        end
      endcase
    end
  end

  // the last line only counts toward the height once the run is finished
  assign total_width  = few;
  assign total_height = (last_child && blocks) ? sat_add(feh, fline) : feh;

  always_comb begin
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    line_h_nxt   = line_h_r;
    ext_w_nxt    = ext_w_r;
    ext_h_nxt    = ext_h_r;
    if (accept) begin
      if (last_child) begin
        cursor_x_nxt = '0;
        cursor_y_nxt = '0;
        line_h_nxt   = '0;
        ext_w_nxt    = '0;
        ext_h_nxt    = '0;
      end else begin
        cursor_x_nxt = fx;
        cursor_y_nxt = fy;
        line_h_nxt   = fline;
        ext_w_nxt    = few;
        ext_h_nxt    = feh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      line_h_r   <= '0;
      ext_w_r    <= '0;
      ext_h_r    <= '0;
    end else begin
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      line_h_r   <= line_h_nxt;
      ext_w_r    <= ext_w_nxt;
      ext_h_r    <= ext_h_nxt;
    end
  end

endmodule

// File: rtl/cbfl_checker.sv
// ----------------------------------------------------------------------------
// cbfl_checker
// Port-level checks for the child box flow layout, bound to the top level.
// ----------------------------------------------------------------------------
module cbfl_checker
  import cbfl_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COORD_BITS-1:0] out_offset_x,
  input logic [COORD_BITS-1:0] out_offset_y,
  input logic [COORD_BITS-1:0] out_total_width,
  input logic [COORD_BITS-1:0] out_total_height,
  input logic                  out_last
);

  // an accepted child always shows up as a pending result next cycle
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted transfer produced no pending result");

  // input only backs up after the result side was held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall without a held result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_offset_x) && $stable(out_offset_y) &&
      $stable(out_total_width) && $stable(out_total_height) && $stable(out_last)))
    else $error("result payload changed while stalled");

endmodule

bind child_box_flow_layout cbfl_checker #(
  .COORD_BITS (COORD_BITS)
) u_cbfl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_offset_x     (out_offset_x),
  .out_offset_y     (out_offset_y),
  .out_total_width  (out_total_width),
  .out_total_height (out_total_height),
  .out_last         (out_last)
);

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for child_box_flow_layout. A short table of directed
// children is followed by random runs of children in every layout mode. Each
// accepted child is placed by a behavioral layout model in the bench, and
// every result transfer is compared field by field with the oldest placement
// still pending. Both sides idle and stall at random in several phases.
// ----------------------------------------------------------------------------
module tb;
  import cbfl_pkg::*;

  localparam int unsigned CB          = 16;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned LONG_HOLD   = 80;
  localparam int unsigned N_DIRECTED  = 23;

  // spare mode code, handled as block flow
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [CB-1:0] width;
    logic [CB-1:0] height;
    logic          absolute;
    logic          last;
  } child_t;

  typedef struct packed {
    logic [CB-1:0] off_x;
    logic [CB-1:0] off_y;
    logic [CB-1:0] cont_w;
    logic [CB-1:0] cont_h;
    logic          last;
  } place_t;

  typedef struct packed {
    logic [CB-1:0] mode_data;
    logic [CB-1:0] wrap_width;
    child_t        child;
    logic          typed;
    place_t        want;
  } step_row_t;

  localparam place_t NO_PLACE = '0;

  localparam step_row_t DIRECTED [N_DIRECTED] = '{
    // reset settings: block flow with zero inner width
    '{16'(MODE_BLOCKS), 16'd0, '{16'd0, 16'd0, 1'b0, 1'b1}, 1'b1,
      '{16'd0, 16'd0, 16'd0, 16'd0, 1'b1}},
    '{16'(MODE_BLOCKS), 16'd0, '{16'd5, 16'd7, 1'b0, 1'b0}, 1'b1,
      '{16'd0, 16'd0, 16'd5, 16'd0, 1'b0}},
    '{16'(MODE_BLOCKS), 16'd0, '{16'd3, 16'd2, 1'b0, 1'b1}, 1'b0, NO_PLACE},
    // widest line, saturating cursor and height
    '{16'(MODE_BLOCKS), 16'hFFFF, '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0}, 1'b1,
      '{16'd0, 16'd0, 16'hFFFF, 16'd0, 1'b0}},
    '{16'(MODE_BLOCKS), 16'hFFFF, '{16'hFFFF, 16'd1, 1'b0, 1'b1}, 1'b1,
      '{16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}},
    // absolute children leave the flow alone
    '{16'(MODE_BLOCKS), 16'hFFFF, '{16'd10, 16'd4, 1'b0, 1'b0}, 1'b1,
      '{16'd0, 16'd0, 16'd10, 16'd0, 1'b0}},
    '{16'(MODE_BLOCKS), 16'hFFFF, '{16'd100, 16'd100, 1'b1, 1'b0}, 1'b1,
      '{16'd0, 16'd0, 16'd10, 16'd0, 1'b0}},
    '{16'(MODE_BLOCKS), 16'hFFFF, '{16'd200, 16'd200, 1'b1, 1'b1}, 1'b0, NO_PLACE},
    // exact fit, then wrap, then a box wider than the line
    '{16'(MODE_BLOCKS), 16'd100, '{16'd60, 16'd5, 1'b0, 1'b0}, 1'b0, NO_PLACE},
    '{16'(MODE_BLOCKS), 16'd100, '{16'd40, 16'd8, 1'b0, 1'b0}, 1'b0, NO_PLACE},
    '{16'(MODE_BLOCKS), 16'd100, '{16'd1, 16'd3, 1'b0, 1'b0}, 1'b0, NO_PLACE},
    '{16'(MODE_BLOCKS), 16'd100, '{16'd101, 16'd2, 1'b0, 1'b1}, 1'b0, NO_PLACE},
    // rows, mode written with junk in the upper bits
    '{{14'h3FFF, MODE_ROWS}, 16'd100, '{16'd7, 16'hFFFF, 1'b0, 1'b0}, 1'b1,
      '{16'd0, 16'd0, 16'd7, 16'hFFFF, 1'b0}},
    '{{14'h3FFF, MODE_ROWS}, 16'd100, '{16'hFFFF, 16'd10, 1'b0, 1'b0}, 1'b0, NO_PLACE},
    '{{14'h3FFF, MODE_ROWS}, 16'd100, '{16'd0, 16'd0, 1'b0, 1'b1}, 1'b0, NO_PLACE},
    // columns
    '{16'(MODE_COLUMNS), 16'd100, '{16'hFFFF, 16'd3, 1'b0, 1'b0}, 1'b1,
      '{16'd0, 16'd0, 16'hFFFF, 16'd3, 1'b0}},
    '{16'(MODE_COLUMNS), 16'd100, '{16'd5, 16'hFFFF, 1'b0, 1'b0}, 1'b0, NO_PLACE},
    '{16'(MODE_COLUMNS), 16'd100, '{16'd0, 16'd0, 1'b1, 1'b1}, 1'b0, NO_PLACE},
    // spare code falls back to block flow
    '{16'(MODE_SPARE), 16'd0, '{16'd0, 16'd9, 1'b0, 1'b0}, 1'b0, NO_PLACE},
    '{16'(MODE_SPARE), 16'd0, '{16'd1, 16'd1, 1'b0, 1'b0}, 1'b0, NO_PLACE},
    // mode switched in the middle of a run
    '{16'(MODE_ROWS), 16'd50, '{16'd20, 16'd30, 1'b0, 1'b0}, 1'b0, NO_PLACE},
    '{16'(MODE_COLUMNS), 16'd50, '{16'd25, 16'd12, 1'b0, 1'b1}, 1'b0, NO_PLACE},
    '{16'(MODE_BLOCKS), 16'd50, '{16'd0, 16'd0, 1'b1, 1'b1}, 1'b0, NO_PLACE}
  };

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [CB-1:0]           in_child_width;
  logic [CB-1:0]           in_child_height;
  logic                    in_is_absolute;
  logic                    in_last_child;
  logic                    out_valid;
  logic                    out_stall;
  logic [CB-1:0]           out_offset_x;
  logic [CB-1:0]           out_offset_y;
  logic [CB-1:0]           out_total_width;
  logic [CB-1:0]           out_total_height;
  logic                    out_last;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CB-1:0]           cfg_data;

  // layout model state and its copy of the registers
  logic [1:0]    mdl_mode;
  logic [CB-1:0] mdl_wrap;
  logic [CB-1:0] cur_x, cur_y, line_h, ext_w, ext_h;

  // register settings as last written by the driver
  logic [CB-1:0] cur_mode_data;
  logic [CB-1:0] cur_wrap;

  place_t        pending_places [$];
  step_row_t     directed_q [$];
  int unsigned   mismatch_count;
  int unsigned   quiet_cycles;
  int unsigned   sender_idle_pct;
  int unsigned   stall_pct;
  bit            long_hold_req;

  child_box_flow_layout #(.COORD_BITS(CB)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_child_width   (in_child_width),
    .in_child_height  (in_child_height),
    .in_is_absolute   (in_is_absolute),
    .in_last_child    (in_last_child),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_offset_x     (out_offset_x),
    .out_offset_y     (out_offset_y),
    .out_total_width  (out_total_width),
    .out_total_height (out_total_height),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [CB-1:0] sat_add(logic [CB-1:0] a, logic [CB-1:0] b);
    logic [CB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CB] ? '1 : s[CB-1:0];
  endfunction

  function automatic logic [CB-1:0] max_of(logic [CB-1:0] a, logic [CB-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // places one child against the running state and returns its result
  function automatic place_t place_child(child_t c);
    place_t r;
    logic   blocks;
    blocks = (mdl_mode == MODE_BLOCKS) || (mdl_mode == MODE_SPARE);
    r = '0;
    r.last = c.last;
    if (!c.absolute) begin
      r.off_x = cur_x;
      r.off_y = cur_y;
      if (blocks) begin
        // wrap test is exact, no saturation
        if (({1'b0, cur_x} + {1'b0, c.width}) > {1'b0, mdl_wrap}) begin
          if (cur_x != '0) cur_y = sat_add(cur_y, line_h);
          cur_x = '0;
          line_h = '0;
        end
        r.off_x = cur_x;
        r.off_y = cur_y;
        line_h = max_of(line_h, c.height);
        cur_x = sat_add(cur_x, c.width);
        ext_w = max_of(ext_w, cur_x);
        ext_h = max_of(ext_h, cur_y);
      end else if (mdl_mode == MODE_ROWS) begin
        cur_y = sat_add(cur_y, c.height);
        ext_h = sat_add(ext_h, c.height);
        ext_w = max_of(ext_w, c.width);
      end else begin
        cur_x = sat_add(cur_x, c.width);
        ext_w = sat_add(ext_w, c.width);
        ext_h = max_of(ext_h, c.height);
      end
    end
    r.cont_w = ext_w;
    r.cont_h = (c.last && blocks) ? sat_add(ext_h, line_h) : ext_h;
    if (c.last) begin
      cur_x = '0;
      cur_y = '0;
      line_h = '0;
      ext_w = '0;
      ext_h = '0;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [CB-1:0] want, logic [CB-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // input side: registers and children as they transfer
  always @(posedge clk) begin
    place_t    predicted;
    step_row_t row;
    if (!rst_n) begin
      mdl_mode = MODE_BLOCKS;
      mdl_wrap = '0;
      cur_x = '0;
      cur_y = '0;
      line_h = '0;
      ext_w = '0;
      ext_h = '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_LAYOUT_MODE) mdl_mode = cfg_data[1:0];
      else if (cfg_index == REG_INNER_WIDTH) mdl_wrap = cfg_data;
    end else if (in_valid && !in_stall) begin
      predicted = place_child('{in_child_width, in_child_height,
                                in_is_absolute, in_last_child});
      if (directed_q.size() != 0) begin
        row = directed_q.pop_front();
        if (row.typed) predicted = row.want;
      end
      pending_places.push_back(predicted);
    end
  end

  // result side
  always @(posedge clk) begin
    place_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_places.size() == 0) begin
        $display("%0t: result with no child pending, x %0d y %0d", $time,
                 out_offset_x, out_offset_y);
        mismatch_count++;
      end else begin
        want = pending_places.pop_front();
        check_field("offset_x", want.off_x, out_offset_x);
        check_field("offset_y", want.off_y, out_offset_y);
        check_field("total_width", want.cont_w, out_total_width);
        check_field("total_height", want.cont_h, out_total_height);
        check_field("last", CB'(want.last), CB'(out_last));
      end
    end
  end

  // ends the run when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stall, or one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_child(child_t c);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_child_width  <= c.width;
    in_child_height <= c.height;
    in_is_absolute  <= c.absolute;
    in_last_child   <= c.last;
    do @(posedge clk); while (in_stall);
  endtask

  // wait until every placement has come back and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_places.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_regs(logic [CB-1:0] mode_data, logic [CB-1:0] wrap);
    cfg_valid <= 1'b1;
    cfg_index <= REG_LAYOUT_MODE;
    cfg_data  <= mode_data;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_INNER_WIDTH;
    cfg_data  <= wrap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_mode_data = mode_data;
    cur_wrap = wrap;
  endtask

  task automatic program_random();
    logic [CB-1:0] mode_data;
    logic [CB-1:0] wrap;
    int unsigned   sel;
    mode_data = (CB'($urandom) & 16'hFFFC) | CB'($urandom_range(0, 3));
    sel = $urandom_range(99);
    if (sel < 10) wrap = '0;
    else if (sel < 20) wrap = '1;
    else if (sel < 70) wrap = CB'($urandom_range(20, 1000));
    else wrap = CB'($urandom);
    program_regs(mode_data, wrap);
  endtask

  // mostly sizes that fit the line, some full range and extremes
  function automatic logic [CB-1:0] pick_size(logic [CB-1:0] scale);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return CB'($urandom_range(0, scale / 3 + 8));
    else if (sel < 85) return CB'($urandom);
    else if (sel < 92) return '1;
    else return '0;
  endfunction

  task automatic send_run(int unsigned len, bit close);
    child_t c;
    for (int unsigned k = 0; k < len; k++) begin
      c.width    = pick_size((cur_wrap == '0) ? CB'(300) : cur_wrap);
      c.height   = pick_size(CB'(300));
      c.absolute = ($urandom_range(99) < 8);
      c.last     = (close && k == len - 1) || ($urandom_range(199) == 0);
      send_child(c);
    end
  endtask

  task automatic random_phase(int unsigned idle, int unsigned stall, int unsigned quota);
    int unsigned sent;
    int unsigned len;
    sender_idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    settle();
    program_random();
    while (sent < quota) begin
      if ($urandom_range(99) < 6) begin
        settle();
        program_random();
      end
      len = $urandom_range(1, 12);
      // a few runs are left open and run on into the next one
      send_run(len, $urandom_range(99) >= 5);
      sent += len;
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_child_width  = '0;
    in_child_height = '0;
    in_is_absolute  = 1'b0;
    in_last_child   = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_LAYOUT_MODE;
    cfg_data        = '0;
    cur_mode_data   = 16'(MODE_BLOCKS);
    cur_wrap        = '0;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    long_hold_req   = 1'b0;
    sender_idle_pct = 23;
    stall_pct       = 23;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].mode_data != cur_mode_data || DIRECTED[i].wrap_width != cur_wrap) begin
        settle();
        program_regs(DIRECTED[i].mode_data, DIRECTED[i].wrap_width);
      end
      directed_q.push_back(DIRECTED[i]);
      send_child(DIRECTED[i].child);
    end
    settle();

    // receiver holds off while the sender keeps offering, then drain
    sender_idle_pct = 0;
    stall_pct = 0;
    long_hold_req = 1'b1;
    send_run(30, 1'b1);
    settle();

    random_phase(0, 0, 500);
    random_phase(78, 0, 500);
    random_phase(0, 78, 500);
    random_phase(23, 23, 500);

    in_valid <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < 1000 && pending_places.size() != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending_places.size() != 0) begin
      $display("%0t: %0d placements never came back", $time, pending_places.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
